>>> sv/key_debounce_event_fifo_unit_defines.svh
// assertion macros for the key debounce event fifo block
// used by sv/key_debounce_event_fifo_unit.sv, no other dependencies
`ifndef KEY_DEBOUNCE_EVENT_FIFO_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_UNIT_DEFINES_SVH

// generic clocked assertion with explicit clock and active-low reset
`define KDEF_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define KDEF_ASSERT(label, prop, msg) \
  `KDEF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> sv/kdef_pkg.sv
// types, constants and helpers of the key debounce event fifo block
// no dependencies; used by key_debounce_event_fifo_unit
`timescale 1ns / 1ps

package kdef_pkg;

  localparam int NUM_KEYS   = 4;
  localparam int FIFO_DEPTH = 16;

  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CODE_W = 6;
  localparam int KIND_W = 3;

  localparam int FILT_W = 7;
  localparam int DBC_W  = 8;
  localparam int LONG_W = 16;
  localparam int REP_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register defaults after reset
  localparam logic              FAST_RESET   = 1'b0;
  localparam logic [FILT_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [LONG_W-1:0] LONG_RESET   = 16'd100;
  localparam logic [REP_W-1:0]  REPEAT_RESET = 8'd0;
  localparam logic [DBC_W-1:0]  DBC_RESET    = DBC_W'(FILTER_RESET / 2);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCAN    = 3'd0,
    KIND_POP_A   = 3'd1,
    KIND_POP_B   = 3'd2,
    KIND_PUSH    = 3'd3,
    KIND_CLEAR_A = 3'd4
  } kind_e;

  // event code offsets: code = 3 * key + offset
  localparam logic [1:0] EVT_DOWN = 2'd1;
  localparam logic [1:0] EVT_UP   = 2'd2;
  localparam logic [1:0] EVT_LONG = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [NUM_KEYS-1:0] key_levels;
    logic [CODE_W-1:0]   push_code;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]   key_code;
    logic [NUM_KEYS-1:0] pressed_mask;
  } out_item_t;

  function automatic logic [CODE_W-1:0] evt_code(input logic [KEY_W-1:0] key,
                                                 input logic [1:0] offset);
    return CODE_W'(3 * int'(key) + int'(offset));
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

>>> sv/key_debounce_event_fifo_unit.sv
// key_debounce_event_fifo_unit: how the block is used
// input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
// transfer: scan tick with raw key levels, pop reader a, pop reader b, push a
// code, or clear reader a. every command gives exactly one result transfer on
// the output channel (out_valid_o / out_stall_i / out_data_o): the popped
// code (0 when that reader sees an empty ring or the command is not a pop)
// and the pressed state of every key after the command.
// a scan walks the keys one per cycle through a single shared key-update
// unit; only the one key that is down can emit two events in a step, and
// its second event then takes an extra S_PUSH2 step on the single ring
// write port before the walk goes on. a scan loads its result in S_DONE
// after the last key step; any other command goes straight to S_DONE.
// the next command is taken once the block is back in S_IDLE.
// in_stall_o is high from the input transfer until the result is loaded;
// the next command is taken while that result still waits for its transfer.
// a stalled receiver holds the output register; a finished command then
// waits in its last step, so no result is lost or overwritten.
// reset restores register defaults, clears keys and ring pointers; ring
// contents stay, a reader never reaches an unwritten slot.
// configuration writes (cfg_we_i) are registered and apply to every later scan or key step, also within a running scan.
`timescale 1ns / 1ps

`include "key_debounce_event_fifo_unit_defines.svh"

module key_debounce_event_fifo_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  kdef_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output kdef_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [kdef_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kdef_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY,
    S_PUSH2,
    S_DONE
  } state_e;

  // configuration registers
  logic                              fast_q;
  logic [kdef_pkg::FILT_W-1:0]       filt_q;
  logic [kdef_pkg::LONG_W-1:0]       long_q;
  logic [kdef_pkg::REP_W-1:0]        rep_ticks_q;
  logic [kdef_pkg::NUM_KEYS-1:0]     act_mask_q;

  // sequencer and per-key state
  state_e                            state_q;
  logic [kdef_pkg::KEY_W-1:0]        k_q;
  logic [kdef_pkg::NUM_KEYS-1:0]     down_q;
  logic [kdef_pkg::NUM_KEYS-1:0]     pf_q;
  logic [kdef_pkg::DBC_W-1:0]        dbc_q  [kdef_pkg::NUM_KEYS];
  logic [kdef_pkg::LONG_W-1:0]       hold_q [kdef_pkg::NUM_KEYS];
  logic [kdef_pkg::REP_W-1:0]        rep_q  [kdef_pkg::NUM_KEYS];
  logic [kdef_pkg::CODE_W-1:0]       code2_q;
  logic                              pop_hit_q;
  logic                              out_valid_q;
  kdef_pkg::out_item_t               out_data_q;

  // ring pointers and storage
  logic [kdef_pkg::PTR_W-1:0]        wp_q;
  logic [kdef_pkg::PTR_W-1:0]        rpa_q;
  logic [kdef_pkg::PTR_W-1:0]        rpb_q;
  logic [kdef_pkg::CODE_W-1:0]       ring_q [kdef_pkg::FIFO_DEPTH];
  logic [kdef_pkg::CODE_W-1:0]       rd_data_q;

  logic                              in_accept;
  logic                              last_key;
  logic [kdef_pkg::NUM_KEYS-1:0]     act_vec;
  logic [kdef_pkg::NUM_KEYS-1:0]     down_d;

  // shared key-update unit outputs
  logic [kdef_pkg::DBC_W-1:0]        key_dbc_d;
  logic                              key_pf_d;
  logic [kdef_pkg::LONG_W-1:0]       key_hold_d;
  logic [kdef_pkg::REP_W-1:0]        key_rep_d;
  logic                              push_a;
  logic                              push_b;
  logic [kdef_pkg::CODE_W-1:0]       code_a;
  logic [kdef_pkg::CODE_W-1:0]       code_b;

  // ring write and read port
  logic                              ring_we;
  logic [kdef_pkg::CODE_W-1:0]       ring_wdata;
  logic [kdef_pkg::PTR_W-1:0]        rd_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign last_key    = (k_q == kdef_pkg::KEY_W'(kdef_pkg::NUM_KEYS - 1));

  // a key is down only when it is the single active key of the scan
  assign act_vec = ~(in_data_i.key_levels ^ act_mask_q);
  assign down_d  = ((act_vec != '0) && ((act_vec & (act_vec - 1'b1)) == '0)) ? act_vec : '0;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q      <= kdef_pkg::FAST_RESET;
      filt_q      <= kdef_pkg::FILTER_RESET;
      long_q      <= kdef_pkg::LONG_RESET;
      rep_ticks_q <= kdef_pkg::REPEAT_RESET;
      act_mask_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kdef_pkg::CFG_FAST_MODE:   fast_q      <= cfg_data_i[0];
        kdef_pkg::CFG_FILTER:      filt_q      <= cfg_data_i[kdef_pkg::FILT_W-1:0];
        kdef_pkg::CFG_LONG:        long_q      <= cfg_data_i[kdef_pkg::LONG_W-1:0];
        kdef_pkg::CFG_REPEAT:      rep_ticks_q <= cfg_data_i[kdef_pkg::REP_W-1:0];
        kdef_pkg::CFG_ACTIVE_MASK: act_mask_q  <= cfg_data_i[kdef_pkg::NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  // shared key-update unit: debounce, press/release edges, long press, repeat
  always_comb begin
    logic                        down;
    logic                        do_held;
    logic                        do_release;
    logic [kdef_pkg::DBC_W-1:0]  dbc;
    logic [kdef_pkg::DBC_W-1:0]  filt8;
    logic [kdef_pkg::DBC_W-1:0]  filt2;
    logic [kdef_pkg::LONG_W-1:0] hold_inc;
    logic [kdef_pkg::REP_W-1:0]  rep_inc;

    down       = down_q[k_q];
    dbc        = dbc_q[k_q];
    filt8      = kdef_pkg::DBC_W'(filt_q);
    filt2      = {filt_q, 1'b0};
    hold_inc   = hold_q[k_q] + 1'b1;
    rep_inc    = rep_q[k_q] + 1'b1;
    do_held    = 1'b0;
    do_release = 1'b0;

    key_dbc_d  = dbc;
    key_pf_d   = pf_q[k_q];
    key_hold_d = hold_q[k_q];
    key_rep_d  = rep_q[k_q];
    push_a     = 1'b0;
    push_b     = 1'b0;
    code_a     = kdef_pkg::evt_code(k_q, kdef_pkg::EVT_DOWN);
    code_b     = kdef_pkg::evt_code(k_q, kdef_pkg::EVT_LONG);

    if (down) begin
      if (fast_q) begin
        do_held = 1'b1;
      end else if (dbc < filt8) begin
        key_dbc_d = filt8;
      end else if (dbc < filt2) begin
        key_dbc_d = dbc + 1'b1;
      end else begin
        do_held = 1'b1;
      end
    end else begin
      if (fast_q) begin
        do_release = 1'b1;
      end else if (dbc > filt8) begin
        key_dbc_d = filt8;
      end else if (dbc != '0) begin
        key_dbc_d = dbc - 1'b1;
      end else begin
        do_release = 1'b1;
      end
      key_hold_d = '0;
      key_rep_d  = '0;
    end

    if (do_held) begin
      if (!pf_q[k_q]) begin
        key_pf_d = 1'b1;
        push_a   = 1'b1;
      end
      if (long_q != '0) begin
        if (hold_q[k_q] < long_q) begin
          key_hold_d = hold_inc;
          push_b     = (hold_inc == long_q);
        end else if (rep_ticks_q != '0) begin
          key_rep_d = rep_inc;
          if (rep_inc >= rep_ticks_q) begin
            key_rep_d = '0;
            push_b    = 1'b1;
            code_b    = kdef_pkg::evt_code(k_q, kdef_pkg::EVT_DOWN);
          end
        end
      end
    end

    if (do_release && pf_q[k_q]) begin
      key_pf_d = 1'b0;
      push_a   = 1'b1;
      code_a   = kdef_pkg::evt_code(k_q, kdef_pkg::EVT_UP);
    end
  end

  // single ring write port: push command, first and second event of a key step
  always_comb begin
    ring_we    = 1'b0;
    ring_wdata = in_data_i.push_code;
    case (state_q)
      S_IDLE: begin
        ring_we = in_accept && (in_data_i.kind == kdef_pkg::KIND_PUSH);
      end
      S_KEY: begin
        ring_we    = push_a || push_b;
        ring_wdata = push_a ? code_a : code_b;
      end
      S_PUSH2: begin
        ring_we    = 1'b1;
        ring_wdata = code2_q;
      end
      default: ;
    endcase
  end

  assign rd_addr = (in_data_i.kind == kdef_pkg::KIND_POP_B) ? rpb_q : rpa_q;

  // ring storage with registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wp_q] <= ring_wdata;
    end
    if (in_accept) begin
      rd_data_q <= ring_q[rd_addr];
    end
  end

  // sequencer, key state, pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      down_q      <= '0;
      pf_q        <= '0;
      for (int i = 0; i < kdef_pkg::NUM_KEYS; i++) begin
        dbc_q[i]  <= kdef_pkg::DBC_RESET;
        hold_q[i] <= '0;
        rep_q[i]  <= '0;
      end
      code2_q     <= '0;
      pop_hit_q   <= 1'b0;
      wp_q        <= '0;
      rpa_q       <= '0;
      rpb_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ring_we) begin
        wp_q <= kdef_pkg::ptr_next(wp_q);
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            pop_hit_q <= 1'b0;
            state_q   <= S_DONE;
            case (in_data_i.kind)
              kdef_pkg::KIND_SCAN: begin
                down_q  <= down_d;
                k_q     <= '0;
                state_q <= S_KEY;
              end
              kdef_pkg::KIND_POP_A: begin
                if (rpa_q != wp_q) begin
                  rpa_q     <= kdef_pkg::ptr_next(rpa_q);
                  pop_hit_q <= 1'b1;
                end
              end
              kdef_pkg::KIND_POP_B: begin
                if (rpb_q != wp_q) begin
                  rpb_q     <= kdef_pkg::ptr_next(rpb_q);
                  pop_hit_q <= 1'b1;
                end
              end
              kdef_pkg::KIND_CLEAR_A: begin
                rpa_q <= wp_q;
              end
              default: ;  // push handled on the ring port, unused kinds do nothing
            endcase
          end
        end

        S_KEY: begin
          dbc_q[k_q]  <= key_dbc_d;
          pf_q[k_q]   <= key_pf_d;
          hold_q[k_q] <= key_hold_d;
          rep_q[k_q]  <= key_rep_d;
          if (push_a && push_b) begin
            // second event of this key goes out on the next cycle
            code2_q <= code_b;
            state_q <= S_PUSH2;
          end else if (last_key) begin
            k_q     <= '0;
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        S_PUSH2: begin
          if (last_key) begin
            k_q     <= '0;
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_KEY;
          end
        end

        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.key_code     <= pop_hit_q ? rd_data_q : '0;
            out_data_q.pressed_mask <= pf_q;
            state_q                 <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a second event slot only ever follows a key step
  `KDEF_ASSERT(a_push2_after_key, (state_q == S_PUSH2) |-> $past(state_q == S_KEY), "push2 without key step")
  // a new result only comes from the final sequencer step
  `KDEF_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result outside done step")
  // clearing reader a leaves it empty
  `KDEF_ASSERT(a_clear_empties_a, (in_accept && (in_data_i.kind == kdef_pkg::KIND_CLEAR_A)) |=> (rpa_q == wp_q), "reader a not empty after clear")
  // key walk always restarts from key zero
  `KDEF_ASSERT(a_key_idx_idle, (state_q == S_IDLE) |-> (k_q == '0), "key index not cleared")

endmodule
